>>> sv/sddr_pkg.sv
// ----------------------------------------------------------------------------
// sddr_pkg
// Shared widths, register indexes and controller/datapath signal groups for
// the S-box difference distribution row block.
// ----------------------------------------------------------------------------
package sddr_pkg;

  localparam int DIFF_W      = 6;   // input difference width
  localparam int OD_W        = 4;   // output difference width
  localparam int CNT_W       = 7;   // pair count width, holds 0..64
  localparam int ROW_W       = 64;  // one S-box row register
  localparam int NUM_ROWS    = 4;
  localparam int NUM_OD      = 16;  // number of output differences
  localparam int IDX_W       = 3;   // config register index width
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [IDX_W-1:0] REG_SBOX_ROW_0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_SBOX_ROW_1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_SBOX_ROW_2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_SBOX_ROW_3 = 3'd3;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch difference, clear counters, rewind indexes
    logic count_en;  // tally one x and advance
    logic emit_adv;  // advance to the next output difference
  } sddr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic x_last;    // sweep is at x = 63
    logic j_last;    // emit index is at output difference 15
  } sddr_sts_t;

endpackage

>>> sv/sbox_difference_distribution_row.sv
// ----------------------------------------------------------------------------
// sbox_difference_distribution_row
// One row of the difference distribution table of a 6-to-4 S-box held in
// four configuration rows.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-----------------
//   s_axis   | in  | tdata[5:0] input_difference               | tvalid/tready
//   m_axis   | out | tdata[3:0] output_difference,             | tvalid/tready
//            |     | tdata[10:4] pair_count, tlast last_of_run |
//   cfg      | in  | cfg_idx_i selects row 0..3, cfg_wdata_i   | cfg_we_i
//
// One request runs in order: the accept, then the x sweep counter over all
// 64 inputs (one x per cycle through the two S-box lookups), then the
// sixteen results from the emit index.
// Reset clears the S-box rows to zero and returns the sequencer to idle.
// A stalled result holds the sequencer; no new request is taken until the
// sixteenth result has gone out.
// ----------------------------------------------------------------------------
module sbox_difference_distribution_row (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [5:0] input_difference, [7:6] zero
  input  logic [sddr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [3:0] output_difference, [10:4] pair_count, [15:11] zero
  output logic [sddr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_we_i,
  input  logic [sddr_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [sddr_pkg::ROW_W-1:0]         cfg_wdata_i
);

  sddr_pkg::sddr_cmd_t             cmd;
  sddr_pkg::sddr_sts_t             sts;
  logic [sddr_pkg::OD_W-1:0]       od;
  logic [sddr_pkg::CNT_W-1:0]      count;

  sddr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sddr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .diff_i      (s_axis_tdata_i[sddr_pkg::DIFF_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .od_o        (od),
    .count_o     (count)
  );

  assign m_axis_tdata_o = {{(sddr_pkg::OUT_TDATA_W - sddr_pkg::CNT_W - sddr_pkg::OD_W){1'b0}},
                           count, od};
  assign m_axis_tlast_o = sts.j_last;

endmodule

>>> sv/sddr_ctrl.sv
// ----------------------------------------------------------------------------
// sddr_ctrl
// Sequencer: accept one request, sweep all 64 inputs, then emit the sixteen
// counts under the output handshake.
// ----------------------------------------------------------------------------
module sddr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sddr_pkg::sddr_sts_t sts_i,
  output sddr_pkg::sddr_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o.start    = 1'b0;
    cmd_o.count_en = 1'b0;
    cmd_o.emit_adv = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd_o.count_en = 1'b1;
        if (sts_i.x_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_adv = 1'b1;
          if (sts_i.j_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A taken request blocks further requests until the run is delivered
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a run is in progress");

  // The final result of a run frees the input side
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && sts_i.j_last |=> in_ready_o && !out_valid_o)
    else $error("input not ready after the last result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.count_en |-> !out_valid_o && !in_ready_o)
    else $error("sweep overlaps a handshake phase");

endmodule

>>> sv/sddr_dp.sv
// ----------------------------------------------------------------------------
// sddr_dp
// Datapath: S-box row registers, input sweep counter, two S-box lookups,
// sixteen pair counters and the emit index.
// ----------------------------------------------------------------------------
module sddr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sddr_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [sddr_pkg::ROW_W-1:0]        cfg_wdata_i,
  input  logic [sddr_pkg::DIFF_W-1:0]       diff_i,
  input  sddr_pkg::sddr_cmd_t               cmd_i,
  output sddr_pkg::sddr_sts_t               sts_o,
  output logic [sddr_pkg::OD_W-1:0]         od_o,
  output logic [sddr_pkg::CNT_W-1:0]        count_o
);

  logic [sddr_pkg::ROW_W-1:0]  sbox_q [sddr_pkg::NUM_ROWS];
  logic [sddr_pkg::DIFF_W-1:0] diff_q;
  logic [sddr_pkg::DIFF_W-1:0] x_q;
  logic [sddr_pkg::OD_W-1:0]   j_q;
  logic [sddr_pkg::CNT_W-1:0]  cnt_q [sddr_pkg::NUM_OD];
  logic [sddr_pkg::OD_W-1:0]   s_a, s_b, od;
  logic [sddr_pkg::DIFF_W-1:0] x_b;

  function automatic logic [sddr_pkg::OD_W-1:0] lookup(
    input logic [sddr_pkg::ROW_W-1:0]  row_word,
    input logic [sddr_pkg::DIFF_W-1:0] x
  );
    logic [3:0] col;
    col = x[4:1];
    return row_word[{col, 2'b00} +: sddr_pkg::OD_W];
  endfunction

  // Row comes from the outer bits 5 and 0
  always_comb begin
    x_b = x_q ^ diff_q;
    s_a = lookup(sbox_q[{x_q[5], x_q[0]}], x_q);
    s_b = lookup(sbox_q[{x_b[5], x_b[0]}], x_b);
    od  = s_a ^ s_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < sddr_pkg::NUM_ROWS; r++) begin
        sbox_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sddr_pkg::REG_SBOX_ROW_0: sbox_q[0] <= cfg_wdata_i;
        sddr_pkg::REG_SBOX_ROW_1: sbox_q[1] <= cfg_wdata_i;
        sddr_pkg::REG_SBOX_ROW_2: sbox_q[2] <= cfg_wdata_i;
        sddr_pkg::REG_SBOX_ROW_3: sbox_q[3] <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      diff_q <= diff_i;
      x_q    <= '0;
      j_q    <= '0;
    end else begin
      if (cmd_i.count_en) begin
        x_q <= x_q + sddr_pkg::DIFF_W'(1);
      end
      if (cmd_i.emit_adv) begin
        j_q <= j_q + sddr_pkg::OD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < sddr_pkg::NUM_OD; k++) begin
      if (cmd_i.start) begin
        cnt_q[k] <= '0;
      end else if (cmd_i.count_en && (od == sddr_pkg::OD_W'(k))) begin
        cnt_q[k] <= cnt_q[k] + sddr_pkg::CNT_W'(1);
      end
    end
  end

  assign sts_o.x_last = (x_q == {sddr_pkg::DIFF_W{1'b1}});
  assign sts_o.j_last = (j_q == {sddr_pkg::OD_W{1'b1}});
  assign od_o         = j_q;
  assign count_o      = cnt_q[j_q];

  a_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> x_q == '0 && j_q == '0)
    else $error("indexes not rewound at run start");

  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_en && !cmd_i.start |=> x_q == $past(x_q) + sddr_pkg::DIFF_W'(1))
    else $error("sweep counter skipped");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_adv |-> count_o <= sddr_pkg::CNT_W'(64))
    else $error("pair count above 64");

endmodule
